// File: src/rc_pulse_moving_average_to_angle_macros.svh
// Assertion macros used by the checking file of the pulse averaging block.
`ifndef RC_PULSE_MOVING_AVERAGE_TO_ANGLE_MACROS_SVH
`define RC_PULSE_MOVING_AVERAGE_TO_ANGLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// File: src/rcma_pkg.sv
package rcma_pkg;

    // Field widths of the input and result words.
    localparam int CH_W    = 4;
    localparam int PW_W    = 12;
    localparam int ANGLE_W = 15;

    // Window sums of up to sixteen 12-bit samples fit in 16 bits.
    localparam int SUM_W  = 16;
    // Ring slot index; windows of up to sixteen samples.
    localparam int SLOT_W = 4;

    // Angle in hundredths of a degree is average * 6 - 9000.
    localparam int ANGLE_OFFSET = 9000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT,
        ST_READ,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    // One entry of the per-channel slot table.
    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] slot;
    } slot_entry_t;

    function automatic logic [ANGLE_W-1:0] avg_to_angle(input logic [PW_W-1:0] avg);
        logic [ANGLE_W-1:0] times4;
        logic [ANGLE_W-1:0] times2;
        times4 = ANGLE_W'({avg, 2'b00});
        times2 = ANGLE_W'({avg, 1'b0});
        return times4 + times2 - ANGLE_W'(ANGLE_OFFSET);
    endfunction

endpackage

// File: src/rcma_ring_ram.sv
module rcma_ring_ram #(
    parameter int DEPTH = 120
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [rcma_pkg::PW_W-1:0]     wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [rcma_pkg::PW_W-1:0]     rd_data
);

    logic [rcma_pkg::PW_W-1:0] mem [DEPTH];
    logic [rcma_pkg::PW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rcma_slot_table.sv
module rcma_slot_table #(
    parameter int CHANNELS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
    output rcma_pkg::slot_entry_t         rd_data,
    input  logic                          wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
    input  rcma_pkg::slot_entry_t         wr_data
);

    rcma_pkg::slot_entry_t mem [CHANNELS];
    rcma_pkg::slot_entry_t rd_data_reg;
    logic [CHANNELS-1:0]   valid_reg;
    logic                  rd_valid_reg;

    // A channel never written reads as slot zero, not yet full.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: src/rcma_div_window.sv
module rcma_div_window #(
    parameter int WINDOW = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rcma_pkg::SUM_W-1:0]    dividend,
    output logic                          done,
    output logic [rcma_pkg::PW_W-1:0]     quotient
);

    // Reciprocal estimate is low by at most one; one compare fixes it.
    localparam int SW    = rcma_pkg::SUM_W;
    localparam int RECIP = (2 ** SW) / WINDOW;

    logic [SW-1:0]       dividend_reg;
    logic [SW-1:0]       dividend_d_reg;
    logic [2*SW-1:0]     prod_reg;
    logic [rcma_pkg::PW_W-1:0] quotient_reg;
    logic                v0_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic [SW-1:0]       q_est;
    logic [SW-1:0]       rem;
    logic [SW-1:0]       q_fix;

    always_comb
    begin
        q_est = prod_reg[2*SW-1:SW];
        rem   = dividend_d_reg - q_est * SW'(WINDOW);
        q_fix = (rem >= SW'(WINDOW)) ? q_est + SW'(1) : q_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= dividend;
        end
        prod_reg       <= dividend_reg * SW'(RECIP);
        dividend_d_reg <= dividend_reg;
        quotient_reg   <= q_fix[rcma_pkg::PW_W-1:0];
    end

    assign done     = v2_reg;
    assign quotient = quotient_reg;

endmodule

// File: src/rc_pulse_moving_average_to_angle.sv
// Channel      Direction  Word layout (lowest bit first)
// s_axis       in         channel[3:0], pulse_width[15:4]
// m_axis       out        out_channel[3:0], average_width[15:4], angle_centi[30:16], zero[31]
//
// An item with a valid channel occupies the block while it walks the channel's ring
// through the single read port of the sample memory and then passes the three-stage
// reciprocal divider.
// An item with a channel out of range goes straight to the output state with a zero average.
// Reset is asynchronous and active low; per-channel valid bits in the slot table and
// per-channel full flags make unwritten samples count as zero, so no clearing pass runs.
// A stalled output word holds the block in its output state; the next input word is
// accepted as soon as the result sits in the output register.
module rc_pulse_moving_average_to_angle #(
    parameter int CHANNELS = 12,
    parameter int WINDOW   = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // channel, pulse_width
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_channel, average_width, angle_centi
);

    localparam int CH_W    = rcma_pkg::CH_W;
    localparam int PW_W    = rcma_pkg::PW_W;
    localparam int SUM_W   = rcma_pkg::SUM_W;
    localparam int SLOT_W  = rcma_pkg::SLOT_W;
    localparam int ANGLE_W = rcma_pkg::ANGLE_W;
    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int RING_AW = $clog2(DEPTH);
    localparam int PAD_W   = 32 - CH_W - PW_W - ANGLE_W;

    rcma_pkg::state_t state_reg, state_next;

    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [PW_W-1:0]    width_reg, width_next;
    logic [RING_AW-1:0] base_reg, base_next;
    logic [SLOT_W-1:0]  lim_reg, lim_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [SLOT_W-1:0]  pend_idx_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PW_W-1:0]    avg_reg, avg_next;

    logic               out_valid_reg, out_valid_next;
    logic [CH_W-1:0]    out_ch_reg;
    logic [PW_W-1:0]    out_avg_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic               out_load;

    logic                  in_accept;
    logic                  ch_in_range;
    logic [CH_AW-1:0]      in_ch_idx;
    logic [CH_AW-1:0]      ch_idx;

    // Slot table port signals.
    logic                  slot_rd_en;
    rcma_pkg::slot_entry_t slot_rd_data;
    logic                  slot_wr_en;
    rcma_pkg::slot_entry_t slot_wr_data;

    // Sample memory port signals.
    logic                  ring_wr_en;
    logic [RING_AW-1:0]    ring_wr_addr;
    logic                  ring_rd_en;
    logic [RING_AW-1:0]    ring_rd_addr;
    logic [PW_W-1:0]       ring_rd_data;

    // Divider port signals.
    logic                  div_start;
    logic                  div_done;
    logic [PW_W-1:0]       div_quotient;

    // Slot bookkeeping for the item being written.
    logic [SLOT_W-1:0]     cur_slot;
    logic                  cur_last;

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign ch_in_range = {1'b0, s_axis_tdata[CH_W-1:0]} < (CH_W + 1)'(CHANNELS);
    assign in_ch_idx   = s_axis_tdata[CH_AW-1:0];
    assign ch_idx      = ch_reg[CH_AW-1:0];

    // A slot pointer at or beyond the window restarts at zero.
    always_comb
    begin
        if ({1'b0, slot_rd_data.slot} >= (SLOT_W + 1)'(WINDOW))
        begin
            cur_slot = '0;
        end
        else
        begin
            cur_slot = slot_rd_data.slot;
        end
        cur_last = (cur_slot == SLOT_W'(WINDOW - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        width_next     = width_reg;
        base_next      = base_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;

        s_axis_tready  = (state_reg == rcma_pkg::ST_IDLE);
        slot_rd_en     = 1'b0;
        slot_wr_en     = 1'b0;
        slot_wr_data   = '0;
        ring_wr_en     = 1'b0;
        ring_wr_addr   = base_reg + RING_AW'(cur_slot);
        ring_rd_en     = 1'b0;
        ring_rd_addr   = base_reg + RING_AW'(idx_reg);
        div_start      = 1'b0;

        // Accumulate a returning sample; slots past the fill limit count as zero.
        if (pend_reg && (pend_idx_reg <= lim_reg))
        begin
            sum_next = sum_reg + SUM_W'(ring_rd_data);
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rcma_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    ch_next    = s_axis_tdata[CH_W-1:0];
                    width_next = s_axis_tdata[CH_W+PW_W-1:CH_W];
                    base_next  = RING_AW'(in_ch_idx) * RING_AW'(WINDOW);
                    if (ch_in_range)
                    begin
                        slot_rd_en = 1'b1;
                        state_next = rcma_pkg::ST_SLOT;
                    end
                    else
                    begin
                        avg_next   = '0;
                        state_next = rcma_pkg::ST_OUT;
                    end
                end
            end
            rcma_pkg::ST_SLOT:
            begin
                ring_wr_en        = 1'b1;
                slot_wr_en        = 1'b1;
                slot_wr_data.full = slot_rd_data.full || cur_last;
                slot_wr_data.slot = cur_last ? '0 : cur_slot + SLOT_W'(1);
                lim_next          = slot_rd_data.full ? SLOT_W'(WINDOW - 1) : cur_slot;
                idx_next          = '0;
                sum_next          = '0;
                state_next        = rcma_pkg::ST_READ;
            end
            rcma_pkg::ST_READ:
            begin
                ring_rd_en = 1'b1;
                pend_next  = 1'b1;
                idx_next   = idx_reg + SLOT_W'(1);
                if (idx_reg == SLOT_W'(WINDOW - 1))
                begin
                    state_next = rcma_pkg::ST_DRAIN;
                end
            end
            rcma_pkg::ST_DRAIN:
            begin
                div_start  = 1'b1;
                state_next = rcma_pkg::ST_DIV;
            end
            rcma_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quotient;
                    state_next = rcma_pkg::ST_OUT;
                end
            end
            rcma_pkg::ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rcma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcma_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        width_reg    <= width_next;
        base_reg     <= base_next;
        lim_reg      <= lim_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        avg_reg      <= avg_next;
        pend_idx_reg <= idx_reg;
        if (out_load)
        begin
            out_ch_reg    <= ch_reg;
            out_avg_reg   <= avg_reg;
            out_angle_reg <= rcma_pkg::avg_to_angle(avg_reg);
        end
    end

    rcma_slot_table #(
        .CHANNELS (CHANNELS)
    ) u_slot_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (slot_rd_en),
        .rd_addr (in_ch_idx),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (ch_idx),
        .wr_data (slot_wr_data)
    );

    rcma_ring_ram #(
        .DEPTH (DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (width_reg),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    rcma_div_window #(
        .WINDOW (WINDOW)
    ) u_div_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_angle_reg, out_avg_reg, out_ch_reg};

endmodule

// File: src/rcma_port_checker.sv
`include "rc_pulse_moving_average_to_angle_macros.svh"

module rcma_port_checker #(
    parameter int CHANNELS = 12
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic [14:0] expected_angle;
    logic        out_ch_bad;
    logic        in_accept;

    assign expected_angle = 15'({3'b000, m_axis_tdata[15:4]} * 15'd6) - 15'd9000;
    assign out_ch_bad     = {1'b0, m_axis_tdata[3:0]} >= 5'(CHANNELS);
    assign in_accept      = s_axis_tvalid && s_axis_tready;

    // A result word that is not taken stays unchanged.
    `RCMA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The angle always follows from the average shown beside it.
    `RCMA_ASSERT_SAME(a_angle_map, clk, rst_n, m_axis_tvalid, m_axis_tdata[30:16] == expected_angle)

    // A channel outside the table always reports a zero average.
    `RCMA_ASSERT_SAME(a_bad_ch_zero, clk, rst_n, m_axis_tvalid && out_ch_bad, m_axis_tdata[15:4] == 12'd0)

    // The block works on one word at a time.
    `RCMA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !s_axis_tready)

endmodule

bind rc_pulse_moving_average_to_angle rcma_port_checker #(
    .CHANNELS (CHANNELS)
) u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
